FILE: sv/label_selected_patch_filter_top_defines.svh
// Assertion macros shared by the checker of the patch filter.
`ifndef LABEL_SELECTED_PATCH_FILTER_TOP_DEFINES_SVH
`define LABEL_SELECTED_PATCH_FILTER_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define LSPF_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lspf assertion failed");

// next-cycle implication
`define LSPF_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lspf assertion failed");

`endif

FILE: sv/lspf_pkg.sv
// Types, constants and field layout of the label-selected patch filter.
package lspf_pkg;

  localparam int MAX_CLASSES_D       = 16;
  localparam int CHANNELS_D          = 3;
  localparam int MAX_PATCH_D         = 5;
  localparam int MAX_COLUMN_LENGTH_D = 1024;
  localparam int RAW_BITS_D          = 16;
  localparam int COEF_BITS_D         = 20;

  localparam int VALUE_W    = 42;
  localparam int IN_DATA_W  = 56;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_USER_W = 2;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  // input tdata layout
  localparam int PIX_LSB   = 0;
  localparam int LABEL_LSB = 16;
  localparam int CLS_LSB   = 20;
  localparam int CHAN_LSB  = 24;
  localparam int TAP_LSB   = 26;
  localparam int COEF_LSB  = 31;
  // input tuser layout
  localparam int FUNC_LSB  = 0;
  localparam int FS_BIT    = 2;

  typedef enum logic [1:0] {
    FUNC_PIXEL = 2'd0,
    FUNC_COEF  = 2'd1,
    FUNC_EMPTY = 2'd2
  } func_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_COLUMN_LENGTH = 2'd0,
    REG_PATCH_ROWS    = 2'd1,
    REG_PATCH_COLS    = 2'd2,
    REG_CHANNELS      = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COL_RD,
    ST_COL_UPD,
    ST_TAP_RD,
    ST_TAP_MUL,
    ST_TAP_ACC,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic col_rd;
    logic col_upd;
    logic ch_init;
    logic ch_next;
    logic tap_rd;
    logic tap_mul;
    logic tap_acc;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic is_pixel;
    logic win_done;
    logic present;
    logic last_tap;
    logic last_ch;
    logic out_free;
  } status_t;

endpackage

FILE: sv/lspf_ctrl.sv
// Sequencer of the patch filter: request intake, line update, tap loop, result.
module lspf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  lspf_pkg::status_t  st,
  output lspf_pkg::cmd_t     cmd,
  output logic               in_ready
);

  lspf_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lspf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      lspf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (st.in_valid) begin
          cmd.accept = 1'b1;
          if (st.is_pixel) state_nxt = lspf_pkg::ST_COL_RD;
        end
      end
      lspf_pkg::ST_COL_RD: begin
        cmd.col_rd = 1'b1;
        state_nxt  = lspf_pkg::ST_COL_UPD;
      end
      lspf_pkg::ST_COL_UPD: begin
        cmd.col_upd = 1'b1;
        if (st.win_done) begin
          cmd.ch_init = 1'b1;
          state_nxt   = st.present ? lspf_pkg::ST_TAP_RD : lspf_pkg::ST_OUT;
        end else begin
          state_nxt = lspf_pkg::ST_IDLE;
        end
      end
      lspf_pkg::ST_TAP_RD: begin
        cmd.tap_rd = 1'b1;
        state_nxt  = lspf_pkg::ST_TAP_MUL;
      end
      lspf_pkg::ST_TAP_MUL: begin
        cmd.tap_mul = 1'b1;
        state_nxt   = lspf_pkg::ST_TAP_ACC;
      end
      lspf_pkg::ST_TAP_ACC: begin
        cmd.tap_acc = 1'b1;
        state_nxt   = st.last_tap ? lspf_pkg::ST_OUT : lspf_pkg::ST_TAP_RD;
      end
      lspf_pkg::ST_OUT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          if (st.last_ch) begin
            state_nxt = lspf_pkg::ST_IDLE;
          end else begin
            cmd.ch_next = 1'b1;
            state_nxt   = st.present ? lspf_pkg::ST_TAP_RD : lspf_pkg::ST_OUT;
          end
        end
      end
      default: state_nxt = lspf_pkg::ST_IDLE;
    endcase
  end

endmodule

FILE: sv/lspf_dp.sv
// Datapath: config registers, line buffers, window, kernel memory, MAC, output register.
module lspf_dp #(
  parameter int MAX_CLASSES       = lspf_pkg::MAX_CLASSES_D,
  parameter int CHANNELS          = lspf_pkg::CHANNELS_D,
  parameter int MAX_PATCH         = lspf_pkg::MAX_PATCH_D,
  parameter int MAX_COLUMN_LENGTH = lspf_pkg::MAX_COLUMN_LENGTH_D,
  parameter int RAW_BITS          = lspf_pkg::RAW_BITS_D,
  parameter int COEF_BITS         = lspf_pkg::COEF_BITS_D
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lspf_pkg::cmd_t                    cmd,
  output lspf_pkg::status_t                 st,
  input  logic                              in_tvalid,
  input  logic [lspf_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic [lspf_pkg::IN_USER_W-1:0]    in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [lspf_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic [lspf_pkg::OUT_USER_W-1:0]   out_tuser,
  output logic                              out_tlast,
  input  logic                              cfg_valid,
  input  logic [lspf_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [lspf_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int NTAPS   = MAX_PATCH * MAX_PATCH + 1;
  localparam int NLINES  = (MAX_PATCH > 1) ? MAX_PATCH - 1 : 1;
  localparam int LW      = NLINES * RAW_BITS;
  localparam int KDEPTH  = MAX_CLASSES * CHANNELS * NTAPS;
  localparam int KA_W    = $clog2(KDEPTH);
  localparam int RP_W    = $clog2(MAX_COLUMN_LENGTH);
  localparam int CL_W    = $clog2(MAX_COLUMN_LENGTH + 1);
  localparam int PC_W    = $clog2(MAX_PATCH + 1);
  localparam int PI_W    = (MAX_PATCH > 1) ? $clog2(MAX_PATCH) : 1;
  localparam int NC_W    = $clog2(CHANNELS + 1);
  localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CLS_W   = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int TP_W    = $clog2(NTAPS);
  localparam int PROD_W  = RAW_BITS + COEF_BITS + 1;
  localparam int VW      = lspf_pkg::VALUE_W;
  localparam int CL_RST  = (MAX_COLUMN_LENGTH < 1024) ? MAX_COLUMN_LENGTH : 1024;
  localparam int PT_RST  = (MAX_PATCH < 5) ? MAX_PATCH : 5;
  localparam int NC_RST  = (CHANNELS < 3) ? CHANNELS : 3;

  function automatic int unsigned clampu(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // field decode
  logic [1:0]            in_func;
  logic                  in_fs;
  logic [RAW_BITS-1:0]   in_pix;
  logic [3:0]            in_label;
  logic [3:0]            in_cls;
  logic [1:0]            in_chan;
  logic [4:0]            in_tap;
  logic [COEF_BITS-1:0]  in_coef;
  logic [7:0]            cls8;
  logic [7:0]            lbl8;

  assign in_func  = in_tuser[lspf_pkg::FUNC_LSB +: 2];
  assign in_fs    = in_tuser[lspf_pkg::FS_BIT];
  assign in_pix   = RAW_BITS'(in_tdata[lspf_pkg::PIX_LSB +: 16]);
  assign in_label = in_tdata[lspf_pkg::LABEL_LSB +: 4];
  assign in_cls   = in_tdata[lspf_pkg::CLS_LSB +: 4];
  assign in_chan  = in_tdata[lspf_pkg::CHAN_LSB +: 2];
  assign in_tap   = in_tdata[lspf_pkg::TAP_LSB +: 5];
  assign in_coef  = COEF_BITS'(in_tdata[lspf_pkg::COEF_LSB +: 20]);
  assign cls8     = 8'(in_cls);

  // configuration
  logic [CL_W-1:0] clen_r;
  logic [PC_W-1:0] rows_r;
  logic [PC_W-1:0] cols_r;
  logic [NC_W-1:0] nch_r;
  int unsigned     cfg_v;

  assign cfg_v = 32'(cfg_data);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clen_r <= CL_W'(CL_RST);
      rows_r <= PC_W'(PT_RST);
      cols_r <= PC_W'(PT_RST);
      nch_r  <= NC_W'(NC_RST);
    end else if (cfg_valid) begin
      unique case (lspf_pkg::cfg_reg_t'(cfg_addr))
        lspf_pkg::REG_COLUMN_LENGTH: clen_r <= CL_W'(clampu(cfg_v, MAX_COLUMN_LENGTH));
        lspf_pkg::REG_PATCH_ROWS:    rows_r <= PC_W'(clampu(cfg_v, MAX_PATCH));
        lspf_pkg::REG_PATCH_COLS:    cols_r <= PC_W'(clampu(cfg_v, MAX_PATCH));
        lspf_pkg::REG_CHANNELS:      nch_r  <= NC_W'(clampu(cfg_v, CHANNELS));
        default: ;
      endcase
    end
  end

  // class presence and kernel memory
  logic [MAX_CLASSES-1:0] present_r;
  logic [COEF_BITS-1:0]   kmem [KDEPTH];
  logic [COEF_BITS-1:0]   kd_r;
  logic                   kwr_ok;
  logic                   kempty_ok;
  logic [KA_W-1:0]        kwaddr;
  logic [KA_W-1:0]        kraddr;
  logic [3:0]             label_r;
  logic [CH_W-1:0]        ch_r;
  logic [TP_W-1:0]        tap_r;

  assign kwr_ok = cmd.accept && (in_func == lspf_pkg::FUNC_COEF) &&
                  (32'(in_cls) < MAX_CLASSES) && (32'(in_chan) < CHANNELS) &&
                  (32'(in_tap) < NTAPS);
  assign kempty_ok = cmd.accept && (in_func == lspf_pkg::FUNC_EMPTY) &&
                     (32'(in_cls) < MAX_CLASSES);
  assign kwaddr = KA_W'((32'(in_cls) * CHANNELS + 32'(in_chan)) * NTAPS + 32'(in_tap));
  assign kraddr = KA_W'((32'(label_r) * CHANNELS + 32'(ch_r)) * NTAPS + 32'(tap_r));
  assign lbl8   = 8'(label_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
    end else if (kwr_ok) begin
      present_r[cls8[CLS_W-1:0]] <= 1'b1;
    end else if (kempty_ok) begin
      present_r[cls8[CLS_W-1:0]] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (kwr_ok) kmem[kwaddr] <= in_coef;
    if (cmd.tap_rd) kd_r <= kmem[kraddr];
  end

  // position tracking and line buffers
  logic [RAW_BITS-1:0] pix_r;
  logic [RP_W-1:0]     row_r;
  logic [PI_W-1:0]     ccnt_r;
  logic [PI_W-1:0]     cols_m1;
  logic [PI_W-1:0]     rows_m1;
  logic [LW-1:0]       col_mem [MAX_COLUMN_LENGTH];
  logic [LW-1:0]       col_rd_r;
  logic [LW-1:0]       col_wr;
  logic                row_wrap;

  assign cols_m1  = PI_W'(cols_r - PC_W'(1));
  assign rows_m1  = PI_W'(rows_r - PC_W'(1));
  assign row_wrap = (32'(row_r) + 1) >= 32'(clen_r);
  // newest pixel goes to line 0, each line moves one deeper
  assign col_wr   = LW'({col_rd_r, pix_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      ccnt_r <= '0;
    end else if (cmd.accept && (in_func == lspf_pkg::FUNC_PIXEL)) begin
      if (in_fs) begin
        row_r  <= '0;
        ccnt_r <= '0;
      end else if (ccnt_r > cols_m1) begin
        ccnt_r <= cols_m1;
      end
    end else if (cmd.col_upd) begin
      if (row_wrap) begin
        row_r  <= '0;
        ccnt_r <= (ccnt_r >= cols_m1) ? cols_m1 : PI_W'(ccnt_r + PI_W'(1));
      end else begin
        row_r <= RP_W'(row_r + RP_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && (in_func == lspf_pkg::FUNC_PIXEL)) begin
      pix_r   <= in_pix;
      label_r <= in_label;
    end
    if (cmd.col_rd) col_rd_r <= col_mem[row_r];
    if (cmd.col_upd) col_mem[row_r] <= col_wr;
  end

  // window: first index is row age, second is column age
  logic [RAW_BITS-1:0] win_r [MAX_PATCH][MAX_PATCH];
  logic [RAW_BITS-1:0] slice [MAX_PATCH];

  always_comb begin
    slice[0] = pix_r;
    for (int k = 1; k < MAX_PATCH; k++) slice[k] = col_rd_r[(k-1)*RAW_BITS +: RAW_BITS];
  end

  always_ff @(posedge clk) begin
    if (cmd.col_upd) begin
      for (int i = MAX_PATCH - 1; i >= 1; i--) win_r[i] <= win_r[i-1];
      for (int j = 0; j < MAX_PATCH; j++) win_r[0][j] <= slice[j];
    end
  end

  // tap loop and MAC
  logic [PI_W-1:0]            wr_r;
  logic [PI_W-1:0]            wc_r;
  logic signed [VW-1:0]       prod_r;
  logic signed [VW-1:0]       acc_r;
  logic signed [COEF_BITS-1:0] kcoef;
  logic signed [PROD_W-1:0]   mul;
  logic signed [63:0]         mul64;
  logic signed [63:0]         bias64;
  logic [RAW_BITS-1:0]        win_sel;

  assign kcoef   = signed'(kd_r);
  assign win_sel = win_r[wr_r][wc_r];
  assign mul     = signed'({1'b0, win_sel}) * kcoef;
  assign mul64   = 64'(mul);
  assign bias64  = 64'(kcoef);

  always_ff @(posedge clk) begin
    if (cmd.ch_init || cmd.ch_next) begin
      ch_r  <= cmd.ch_init ? '0 : CH_W'(ch_r + CH_W'(1));
      tap_r <= '0;
      wr_r  <= rows_m1;
      wc_r  <= cols_m1;
      acc_r <= '0;
    end else begin
      if (cmd.tap_mul) begin
        prod_r <= (tap_r == '0) ? bias64[VW-1:0] : mul64[VW-1:0];
      end
      if (cmd.tap_acc) begin
        acc_r <= (tap_r == '0) ? prod_r : acc_r + prod_r;
        tap_r <= TP_W'(tap_r + TP_W'(1));
        if (tap_r != '0) begin
          if (wr_r == '0) begin
            wr_r <= rows_m1;
            wc_r <= PI_W'(wc_r - PI_W'(1));
          end else begin
            wr_r <= PI_W'(wr_r - PI_W'(1));
          end
        end
      end
    end
  end

  // output register
  logic                                out_valid_r;
  logic [VW-1:0]                       out_value_r;
  logic [lspf_pkg::OUT_USER_W-1:0]     out_ch_r;
  logic                                out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_value_r <= acc_r;
      out_ch_r    <= lspf_pkg::OUT_USER_W'(ch_r);
      out_last_r  <= st.last_ch;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = lspf_pkg::OUT_DATA_W'(out_value_r);
  assign out_tuser  = out_ch_r;
  assign out_tlast  = out_last_r;

  // status
  assign st.in_valid = in_tvalid;
  assign st.is_pixel = (in_func == lspf_pkg::FUNC_PIXEL);
  assign st.win_done = (32'(row_r) >= 32'(rows_r) - 1) && (32'(ccnt_r) >= 32'(cols_r) - 1);
  assign st.present  = (32'(label_r) < MAX_CLASSES) && present_r[lbl8[CLS_W-1:0]];
  assign st.last_tap = (tap_r != '0) && (wr_r == '0) && (wc_r == '0);
  assign st.last_ch  = (32'(ch_r) == 32'(nch_r) - 1);
  assign st.out_free = !out_valid_r || out_tready;

endmodule

FILE: sv/label_selected_patch_filter_top.sv
// Top level of the label-selected patch filter.
//
//  channel | dir | handshake         | payload
//  in_     | in  | in_tvalid/tready  | tdata pixel,label,class,channel,tap,coef; tuser func,fs
//  out_    | out | out_tvalid/tready | tdata value; tuser out_channel; tlast last
//  cfg_    | in  | cfg_valid/ready   | cfg_addr register index, cfg_data value
//
// Coefficient and empty-class requests are taken in the idle state; a pixel passes line
// read and line update. A completing window then runs, per channel, tap read, multiply
// and accumulate over the bias and rows*cols taps, then the result (an empty class only
// the result), serialised by the one shared multiplier and the single kernel read port.
// Reset is synchronous; line buffers and kernels are undefined until written, so
// there is no clearing pass. A stalled output holds the sequencer before the next channel.
module label_selected_patch_filter_top #(
  parameter int MAX_CLASSES       = lspf_pkg::MAX_CLASSES_D,
  parameter int CHANNELS          = lspf_pkg::CHANNELS_D,
  parameter int MAX_PATCH         = lspf_pkg::MAX_PATCH_D,
  parameter int MAX_COLUMN_LENGTH = lspf_pkg::MAX_COLUMN_LENGTH_D,
  parameter int RAW_BITS          = lspf_pkg::RAW_BITS_D,
  parameter int COEF_BITS         = lspf_pkg::COEF_BITS_D
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // pixel[15:0] label[19:16] class_index[23:20] channel[25:24] tap[30:26] coefficient[50:31]
  input  logic [lspf_pkg::IN_DATA_W-1:0]   in_tdata,
  // func[1:0] frame_start[2]
  input  logic [lspf_pkg::IN_USER_W-1:0]   in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // value[41:0]
  output logic [lspf_pkg::OUT_DATA_W-1:0]  out_tdata,
  // out_channel[1:0]
  output logic [lspf_pkg::OUT_USER_W-1:0]  out_tuser,
  output logic                             out_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lspf_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [lspf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  lspf_pkg::cmd_t    cmd;
  lspf_pkg::status_t st;

  assign cfg_ready = 1'b1;

  lspf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .st       (st),
    .cmd      (cmd),
    .in_ready (in_tready)
  );

  lspf_dp #(
    .MAX_CLASSES       (MAX_CLASSES),
    .CHANNELS          (CHANNELS),
    .MAX_PATCH         (MAX_PATCH),
    .MAX_COLUMN_LENGTH (MAX_COLUMN_LENGTH),
    .RAW_BITS          (RAW_BITS),
    .COEF_BITS         (COEF_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_tvalid  (in_tvalid),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

endmodule

FILE: sv/lspf_checker.sv
// Port-level checker of the patch filter and its bind.
`include "label_selected_patch_filter_top_defines.svh"

module lspf_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [lspf_pkg::IN_USER_W-1:0]   in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [lspf_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic                             out_tlast
);

  // stalled result holds
  `LSPF_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast))
  // a pixel request keeps the input closed while its line update runs
  `LSPF_ASSERT_NXT(a_pix_busy, in_tvalid && in_tready && (in_tuser[1:0] == lspf_pkg::FUNC_PIXEL), !in_tready)
  // results are only produced while the sequencer is busy
  `LSPF_ASSERT_IMP(a_out_busy, $rose(out_tvalid), !$past(in_tready))

endmodule

bind label_selected_patch_filter_top lspf_checker u_lspf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

FILE: tb/sv/tb.sv
// Self-checking testbench for the label-selected patch filter top level.
module tb;
  import lspf_pkg::*;

  localparam int NTAP      = MAX_PATCH_D * MAX_PATCH_D + 1;
  localparam int NLINE     = MAX_PATCH_D - 1;
  localparam int DRAIN_CYC = 300;
  localparam int LIMIT_CYC = 3000000;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  func;
    logic [15:0] pixel;
    logic [3:0]  label;
    logic        fs;
    logic [3:0]  cls;
    logic [1:0]  chan;
    logic [4:0]  tap;
    logic [19:0] coef;
  } req_t;

  typedef struct {
    logic [1:0]         chan;
    logic [VALUE_W-1:0] value;
    logic               last;
  } filt_out_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready, out_tlast;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [IN_USER_W-1:0]  in_tuser;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic cfg_valid, cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_data;

  label_selected_patch_filter_top u_top (.*);

  // shadow copy of the filter state
  int unsigned sh_len, sh_rows, sh_cols, sh_nch;
  logic [15:0] sh_lines [NLINE][MAX_COLUMN_LENGTH_D];
  logic [15:0] sh_win [MAX_PATCH_D][MAX_PATCH_D];
  logic signed [19:0] sh_kern [MAX_CLASSES_D*CHANNELS_D*NTAP];
  bit sh_present [MAX_CLASSES_D];
  int unsigned sh_row, sh_ccount;

  req_t      pending_q [$];
  filt_out_t filt_q [$];
  req_t      cur_req;
  int        errors = 0;
  int        results_seen = 0;
  longint    cycles = 0;
  int        loaded [2] = '{0, 9};

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned clampv(int unsigned v, int unsigned lo, int unsigned hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  task automatic predict_filter(input req_t q);
    int unsigned r, cc;
    logic [15:0] slice [MAX_PATCH_D];
    longint acc;
    int base;
    if (q.func == FUNC_COEF) begin
      if (q.chan < CHANNELS_D && q.tap < NTAP) begin
        sh_kern[(q.cls * CHANNELS_D + q.chan) * NTAP + q.tap] = q.coef;
        sh_present[q.cls] = 1;
      end
    end else if (q.func == FUNC_EMPTY) begin
      sh_present[q.cls] = 0;
    end else if (q.func == FUNC_PIXEL) begin
      if (q.fs) begin
        sh_row = 0;
        sh_ccount = 0;
      end
      r = sh_row >= MAX_COLUMN_LENGTH_D ? 0 : sh_row;
      cc = sh_ccount > sh_cols - 1 ? sh_cols - 1 : sh_ccount;
      slice[0] = q.pixel;
      for (int k = 1; k < MAX_PATCH_D; k++) slice[k] = sh_lines[k-1][r];
      for (int k = MAX_PATCH_D - 1; k >= 2; k--) sh_lines[k-1][r] = sh_lines[k-2][r];
      sh_lines[0][r] = q.pixel;
      for (int i = MAX_PATCH_D - 1; i >= 1; i--)
        for (int j = 0; j < MAX_PATCH_D; j++) sh_win[i][j] = sh_win[i-1][j];
      for (int j = 0; j < MAX_PATCH_D; j++) sh_win[0][j] = slice[j];
      if (r >= sh_rows - 1 && cc >= sh_cols - 1) begin
        for (int ch = 0; ch < sh_nch; ch++) begin
          acc = 0;
          if (sh_present[q.label]) begin
            base = (q.label * CHANNELS_D + ch) * NTAP;
            acc = longint'(sh_kern[base]);
            for (int b = 0; b < sh_cols; b++)
              for (int a = 0; a < sh_rows; a++)
                acc += longint'({1'b0, sh_win[sh_rows-1-a][sh_cols-1-b]})
                       * longint'(sh_kern[base + 1 + a + sh_rows * b]);
          end
          filt_q.push_back('{ch[1:0], acc[VALUE_W-1:0], ch == sh_nch - 1});
        end
      end
      if (r + 1 >= sh_len) begin
        sh_row = 0;
        sh_ccount = cc + 1 > sh_cols - 1 ? sh_cols - 1 : cc + 1;
      end else begin
        sh_row = r + 1;
        sh_ccount = cc;
      end
    end
  endtask

  // input driver: bursts with random gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    logic nv;
    if (!rst_n) begin
      in_tvalid <= 0;
      in_tdata <= '0;
      in_tuser <= '0;
    end else begin
      nv = in_tvalid;
      if (in_tvalid && in_tready) begin
        predict_filter(cur_req);
        nv = 0;
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_q.size() != 0) begin
          cur_req = pending_q.pop_front();
          in_tdata <= {5'b0, cur_req.coef, cur_req.tap, cur_req.chan, cur_req.cls,
                       cur_req.label, cur_req.pixel};
          in_tuser <= {cur_req.fs, cur_req.func};
          nv = 1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(0, 6);
            gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
          end
        end
      end
      in_tvalid <= nv;
    end
  end

  // result monitor with its own stall pattern
  int stall_mode = 0, mode_left = 0, long_hold = 0;
  bit long_done = 0;
  always @(posedge clk) begin
    filt_out_t e;
    if (!rst_n) begin
      out_tready <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (filt_q.size() == 0) begin
          $error("unexpected result value=%h", out_tdata[VALUE_W-1:0]);
          errors++;
        end else begin
          e = filt_q.pop_front();
          if (out_tuser[1:0] !== e.chan) begin
            $error("out_channel exp %0d got %0d", e.chan, out_tuser[1:0]);
            errors++;
          end
          if (out_tdata[VALUE_W-1:0] !== e.value) begin
            $error("value exp %h got %h", e.value, out_tdata[VALUE_W-1:0]);
            errors++;
          end
          if (out_tlast !== e.last) begin
            $error("last exp %0d got %0d", e.last, out_tlast);
            errors++;
          end
        end
      end
      if (!long_done && out_tvalid && results_seen >= 10) begin
        long_done = 1;
        long_hold = 3000;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(16, 128);
      end else begin
        mode_left--;
      end
      if (long_hold > 0) begin
        long_hold--;
        out_tready <= 0;
      end else begin
        case (stall_mode)
          0: out_tready <= 1;
          1: out_tready <= $urandom_range(0, 1);
          default: out_tready <= $urandom_range(0, 3) == 0;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYC) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic req_t pix_req(logic [15:0] p, logic [3:0] lab, logic fs);
    req_t q = '{FUNC_PIXEL, 16'h0, 4'h0, 1'b0, 4'h0, 2'h0, 5'h0, 20'h0};
    q.pixel = p;
    q.label = lab;
    q.fs = fs;
    q.coef = $urandom;
    return q;
  endfunction

  function automatic req_t coef_req(logic [3:0] c, logic [1:0] ch, logic [4:0] t,
                                    logic [19:0] v);
    req_t q = '{FUNC_COEF, 16'h0, 4'h0, 1'b0, 4'h0, 2'h0, 5'h0, 20'h0};
    q.cls = c;
    q.chan = ch;
    q.tap = t;
    q.coef = v;
    q.pixel = $urandom;
    return q;
  endfunction

  function automatic req_t empty_req(logic [3:0] c);
    req_t q = '{FUNC_EMPTY, 16'h0, 4'h0, 1'b0, 4'h0, 2'h0, 5'h0, 20'h0};
    q.cls = c;
    return q;
  endfunction

  function automatic logic [19:0] rand_coef();
    case ($urandom_range(0, 9))
      0: return 20'h80000;
      1: return 20'h7FFFF;
      2: return $urandom_range(0, 4095);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_pix();
    case ($urandom_range(0, 7))
      0: return 16'hFFFF;
      1: return 16'h0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_idle();
    while (pending_q.size() != 0 || in_tvalid || filt_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t a, logic [15:0] d);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_addr <= a;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    case (a)
      REG_COLUMN_LENGTH: sh_len = clampv(d, 1, MAX_COLUMN_LENGTH_D);
      REG_PATCH_ROWS:    sh_rows = clampv(d, 1, MAX_PATCH_D);
      REG_PATCH_COLS:    sh_cols = clampv(d, 1, MAX_PATCH_D);
      default:           sh_nch = clampv(d, 1, CHANNELS_D);
    endcase
  endtask

  task automatic configure(logic [15:0] len, logic [15:0] rows, logic [15:0] cols,
                           logic [15:0] nch);
    wait_idle();
    write_reg(REG_COLUMN_LENGTH, len);
    write_reg(REG_PATCH_ROWS, rows);
    write_reg(REG_PATCH_COLS, cols);
    write_reg(REG_CHANNELS, nch);
  endtask

  // one frame of npix pixels with kernel traffic and noise mixed in
  task automatic push_frame(int npix);
    logic [3:0] lab;
    int pick;
    for (int n = 0; n < npix; n++) begin
      pick = $urandom_range(0, 19);
      if (pick == 0)
        pending_q.push_back(empty_req($urandom));
      else if (pick == 1)
        pending_q.push_back(coef_req(loaded[$urandom_range(0, 1)], $urandom_range(0, 2),
                                     $urandom_range(0, NTAP - 1), rand_coef()));
      else if (pick == 2)
        pending_q.push_back(coef_req($urandom, 2'd3, $urandom, $urandom));
      else if (pick == 3)
        pending_q.push_back(coef_req($urandom, $urandom, $urandom_range(NTAP, 31), $urandom));
      else if (pick == 4) begin
        pending_q.push_back(pix_req($urandom, $urandom, $urandom));
        pending_q[$].func = FUNC_UNUSED;
      end
      lab = $urandom_range(0, 3) == 0 ? 4'($urandom) : 4'(loaded[$urandom_range(0, 1)]);
      // an early restart now and then breaks the frame
      pending_q.push_back(pix_req(rand_pix(), lab, n == 0 || $urandom_range(0, 150) == 0));
    end
  endtask

  initial begin
    int len, rows, cols;
    rst_n = 0;
    cfg_valid = 0;
    cfg_addr = REG_COLUMN_LENGTH;
    cfg_data = '0;
    sh_len = MAX_COLUMN_LENGTH_D;
    sh_rows = 5;
    sh_cols = 5;
    sh_nch = 3;
    foreach (sh_lines[i, j]) sh_lines[i][j] = '0;
    foreach (sh_win[i, j]) sh_win[i][j] = '0;
    foreach (sh_kern[i]) sh_kern[i] = '0;
    foreach (sh_present[i]) sh_present[i] = 0;
    sh_row = 0;
    sh_ccount = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;

    // directed: ignored codes, out-of-range writes, an empty class
    pending_q.push_back(pix_req(16'hFFFF, 4'hF, 1'b1));
    pending_q[$].func = FUNC_UNUSED;
    pending_q.push_back(coef_req(4'h3, 2'd3, 5'd1, 20'h7FFFF));
    pending_q.push_back(coef_req(4'h3, 2'd0, 5'd26, 20'h80000));
    pending_q.push_back(coef_req(4'hC, 2'd2, 5'd31, 20'hFFFFF));
    pending_q.push_back(empty_req(4'h7));
    pending_q.push_back(pix_req(16'hFFFF, 4'h0, 1'b1));
    pending_q.push_back(pix_req(16'h0000, 4'h3, 1'b0));

    // full kernels for the classes that may be present
    foreach (loaded[c])
      for (int ch = 0; ch < CHANNELS_D; ch++)
        for (int t = 0; t < NTAP; t++)
          pending_q.push_back(coef_req(loaded[c], ch, t, rand_coef()));
    pending_q.push_back(empty_req(4'hA));

    // directed settings, extremes first
    configure(16'd7, 16'd5, 16'd5, 16'd3);
    push_frame(7 * 6);
    configure(16'd0, 16'd0, 16'd0, 16'd0);
    push_frame(12);
    configure(16'd3, 16'd5, 16'd2, 16'd2);
    push_frame(3 * 4);
    configure(16'hFFFF, 16'd7, 16'd7, 16'hFFFF);
    push_frame(8);
    configure(16'd1024, 16'd5, 16'd1, 16'd3);
    push_frame(12);
    configure(16'd5, 16'd3, 16'd4, 16'd2);
    push_frame(5 * 6);

    // random settings, short columns
    for (int ph = 0; ph < 2; ph++) begin
      len = $urandom_range(1, 6);
      rows = $urandom_range(1, 5);
      cols = $urandom_range(1, 5);
      configure(len, rows, cols, $urandom_range(1, 3));
      push_frame(len * $urandom_range(cols, cols + 3));
    end

    wait_idle();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/lspf_pkg.sv
sv/lspf_ctrl.sv
sv/lspf_dp.sv
sv/label_selected_patch_filter_top.sv
sv/lspf_checker.sv
tb/sv/tb.sv
